/* sv/lru_pkg.sv */
// Package for the Legendre recurrence unit: widths, fixed-point constants,
// kind codes, the request and response types of the shared multiplier and
// the saturating subtract. Used by every other file of the block.
package lru_pkg;

    localparam int MAX_DEGREE = 64;
    localparam int FRAC_BITS  = 30;
    localparam int RECIP_BITS = 32;

    localparam int KIND_W   = 2;
    localparam int DEGREE_W = 7;
    localparam int X_W      = 32;
    localparam int VALUE_W  = 64;
    localparam int DEG_W    = $clog2(MAX_DEGREE + 1);
    localparam int COEF_W   = DEG_W + 2;
    localparam int MULB_W   = RECIP_BITS + 1;

    localparam logic [KIND_W-1:0] KIND_PN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAIR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_D1   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_D2   = 2'd3;

    localparam logic signed [X_W-1:0]     X_ONE     = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [X_W-1:0]     X_NEG_ONE = -X_ONE;
    localparam logic signed [VALUE_W-1:0] P_ONE     = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [VALUE_W-1:0] P_NEG_ONE = -P_ONE;
    localparam logic signed [VALUE_W-1:0] P_THREE   = 64'sd3 <<< FRAC_BITS;

    typedef enum logic [1:0] {
        SH_INT,
        SH_FRAC,
        SH_RECIP
    } t_shift;

    typedef struct packed {
        logic signed [VALUE_W-1:0] a;
        logic [MULB_W-1:0]         b;
        t_shift                    sh;
        logic                      negb;
    } t_mul_req;

    typedef struct packed {
        logic                      done;
        logic signed [VALUE_W-1:0] result;
    } t_mul_rsp;

    function automatic logic signed [VALUE_W-1:0] sat_sub(
        input logic signed [VALUE_W-1:0] a,
        input logic signed [VALUE_W-1:0] b
    );
        logic [VALUE_W:0] d;
        d = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
        if (d[VALUE_W] != d[VALUE_W-1]) begin
            sat_sub = d[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                 : {1'b0, {(VALUE_W-1){1'b1}}};
        end else begin
            sat_sub = d[VALUE_W-1:0];
        end
    endfunction

endpackage

/* sv/lru_if.sv */
// Handshake interfaces of the Legendre recurrence unit: the input item
// channel and the result item channel. Depends on lru_pkg.
interface lru_in_if;
    import lru_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [DEGREE_W-1:0]      degree;
    logic signed [X_W-1:0]    x_value;

    modport source (output valid, output kind, output degree, output x_value, input ready);
    modport sink   (input valid, input kind, input degree, input x_value, output ready);
endinterface

interface lru_out_if;
    import lru_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] previous_value;

    modport source (output valid, output value, output previous_value, input ready);
    modport sink   (input valid, input value, input previous_value, output ready);
endinterface

/* sv/lru_mul.sv */
// Shared multiplier of the Legendre recurrence unit: signed 64-bit value
// times an unsigned 33-bit factor, rounded shift and saturation, built on
// one 32 by 33 bit multiplier used twice per operation. Depends on lru_pkg.
module lru_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  lru_pkg::t_mul_req i_req,
    output lru_pkg::t_mul_rsp o_rsp
);
    import lru_pkg::*;

    typedef enum logic [1:0] {
        M_IDLE,
        M_LO,
        M_HI,
        M_FIN
    } t_mstate;

    t_mstate                   r_state;
    logic [VALUE_W-1:0]        r_mag;
    logic [MULB_W-1:0]         r_b;
    t_shift                    r_sh;
    logic                      r_neg;
    logic                      r_negb;
    logic [64:0]               r_pl;
    logic [64:0]               r_ph;
    logic signed [VALUE_W-1:0] r_result;
    logic                      r_done;

    logic [VALUE_W-1:0]        n_mag;
    logic [31:0]               w_mul_a;
    logic [64:0]               w_prod;
    logic [96:0]               w_full;
    logic [96:0]               w_round;
    logic [96:0]               w_shifted;
    logic [96:0]               w_lim;
    logic                      w_big_lim;
    logic [VALUE_W-1:0]        w_mag;
    logic signed [VALUE_W-1:0] n_result;

    always_comb begin
        n_mag = i_req.a[VALUE_W-1] ? (~i_req.a + 64'd1) : i_req.a;
    end

    assign w_mul_a = (r_state == M_HI) ? r_mag[63:32] : r_mag[31:0];
    assign w_prod  = {33'b0, w_mul_a} * {32'b0, r_b};
    assign w_full  = {r_ph, 32'b0} + {32'b0, r_pl};

    always_comb begin
        w_round   = w_full;
        w_shifted = w_full;
        case (r_sh)
            SH_INT: begin
                w_round   = w_full;
                w_shifted = w_full;
            end
            SH_FRAC: begin
                w_round   = w_full + (97'd1 << (FRAC_BITS - 1));
                w_shifted = w_round >> FRAC_BITS;
            end
            SH_RECIP: begin
                w_round   = w_full + (97'd1 << (RECIP_BITS - 1));
                w_shifted = w_round >> RECIP_BITS;
            end
            default: begin
                w_round   = w_full;
                w_shifted = w_full;
            end
        endcase
    end

    // A negative result may reach the full negative range only when the
    // sign comes from the value itself, not from a negative factor.
    assign w_big_lim = r_neg && !r_negb;
    assign w_lim     = {33'b0, w_big_lim, {63{~w_big_lim}}};
    assign w_mag     = (w_shifted > w_lim) ? w_lim[63:0] : w_shifted[63:0];

    always_comb begin
        n_result = r_neg ? $signed(~w_mag + 64'd1) : $signed(w_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_mag   <= n_mag;
                        r_b     <= i_req.b;
                        r_sh    <= i_req.sh;
                        r_neg   <= i_req.a[VALUE_W-1] ^ i_req.negb;
                        r_negb  <= i_req.negb;
                        r_state <= M_LO;
                    end
                end
                M_LO: begin
                    r_pl    <= w_prod;
                    r_state <= M_HI;
                end
                M_HI: begin
                    r_ph    <= w_prod;
                    r_state <= M_FIN;
                end
                M_FIN: begin
                    r_result <= n_result;
                    r_done   <= 1'b1;
                    r_state  <= M_IDLE;
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_result;

endmodule

/* sv/legendre_recurrence_unit.sv */
// Legendre recurrence unit, top level: input handling, recurrence sequencer,
// reciprocal table and result register. Depends on lru_pkg, lru_if, lru_mul.
//
// The unit takes one item at a time and is not ready while it works. Each
// recurrence step is four operations through the one shared 32 by 33 bit
// multiplier plus a loop test. An item takes s recurrence steps, where s is
// n - 1 for kinds 0 to 2 and n - 2 for kind 3 (no steps for the low-degree
// cases and for kind 0 at x = +1 or -1). A finished result is held in the
// output register until it is taken, and the next item is accepted after that.
module legendre_recurrence_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lru_in_if.sink     i_in,
    lru_out_if.source  o_out
);
    import lru_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL1,
        S_MULX,
        S_MUL2,
        S_DIV,
        S_OUT
    } t_state;

    t_state                    r_state;
    logic [KIND_W-1:0]         r_kind;
    logic [DEG_W-1:0]          r_n;
    logic [DEG_W-1:0]          r_k;
    logic [MULB_W-1:0]         r_xmag;
    logic                      r_xneg;
    logic signed [VALUE_W-1:0] r_p;
    logic signed [VALUE_W-1:0] r_pm;
    logic signed [VALUE_W-1:0] r_t;
    logic                      r_mul_start;
    t_mul_req                  r_mul_req;
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] r_prev;

    logic signed [X_W-1:0]     n_x;
    logic signed [X_W:0]       n_xe;
    logic [DEG_W-1:0]          n_n;
    logic [DEG_W-1:0]          n_k;
    logic signed [VALUE_W-1:0] n_p;
    logic signed [VALUE_W-1:0] n_pm;
    logic signed [VALUE_W-1:0] n_x64;

    logic [DEG_W:0]            w_c1;
    logic [COEF_W-1:0]         w_c2;
    logic [DEG_W-1:0]          w_d;
    logic [MULB_W-1:0]         w_recip [MAX_DEGREE+1];
    t_mul_rsp                  w_rsp;

    for (genvar g = 0; g <= MAX_DEGREE; g++) begin : g_recip
        localparam logic [63:0] Den = (g == 0) ? 64'd1 : 64'(g);
        localparam logic [63:0] Rc  = ((64'd1 << RECIP_BITS) + Den / 2) / Den;
        assign w_recip[g] = MULB_W'(Rc);
    end

    always_comb begin
        if (i_in.x_value > X_ONE) begin
            n_x = X_ONE;
        end else if (i_in.x_value < X_NEG_ONE) begin
            n_x = X_NEG_ONE;
        end else begin
            n_x = i_in.x_value;
        end
        n_xe  = {n_x[X_W-1], n_x};
        n_x64 = {{(VALUE_W-X_W){n_x[X_W-1]}}, n_x};
        if (int'(i_in.degree) > MAX_DEGREE) begin
            n_n = DEG_W'(MAX_DEGREE);
        end else begin
            n_n = DEG_W'(i_in.degree);
        end

        n_pm = P_ONE;
        n_p  = (n_n == '0) ? P_ONE : n_x64;
        n_k  = DEG_W'(1);
        case (i_in.kind)
            KIND_PN: begin
                // At the two ends the value is known exactly.
                if (n_n >= DEG_W'(2) && (n_x == X_ONE || n_x == X_NEG_ONE)) begin
                    n_p = (n_x == X_NEG_ONE && n_n[0]) ? P_NEG_ONE : P_ONE;
                    n_k = n_n;
                end
            end
            KIND_PAIR: begin
                n_p = (n_n == '0) ? P_ONE : n_x64;
            end
            KIND_D1: begin
                n_pm = '0;
                n_p  = (n_n == '0) ? '0 : P_ONE;
            end
            KIND_D2: begin
                n_pm = '0;
                n_p  = (n_n <= DEG_W'(1)) ? '0 : P_THREE;
                n_k  = DEG_W'(2);
            end
            default: begin
                n_pm = P_ONE;
            end
        endcase
    end

    always_comb begin
        w_c1 = {r_k, 1'b1};
        case (r_kind)
            KIND_PN, KIND_PAIR: begin
                w_c2 = COEF_W'(r_k);
                w_d  = r_k + DEG_W'(1);
            end
            KIND_D1: begin
                w_c2 = COEF_W'(r_k) + COEF_W'(1);
                w_d  = r_k;
            end
            KIND_D2: begin
                w_c2 = COEF_W'(r_k) + COEF_W'(2);
                w_d  = r_k - DEG_W'(1);
            end
            default: begin
                w_c2 = COEF_W'(r_k);
                w_d  = r_k;
            end
        endcase
    end

    lru_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_req   (r_mul_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mul_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_kind  <= i_in.kind;
                        r_n     <= n_n;
                        r_k     <= n_k;
                        r_xmag  <= n_x[X_W-1] ? MULB_W'(-n_xe) : MULB_W'(n_xe);
                        r_xneg  <= n_x[X_W-1];
                        r_p     <= n_p;
                        r_pm    <= n_pm;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_k < r_n) begin
                        r_mul_start <= 1'b1;
                        r_mul_req   <= '{a: r_p, b: MULB_W'(w_c1), sh: SH_INT,
                                         negb: 1'b0};
                        r_state     <= S_MUL1;
                    end else begin
                        r_value     <= r_p;
                        r_prev      <= (r_kind == KIND_PAIR) ? r_pm : '0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_MUL1: begin
                    if (w_rsp.done) begin
                        r_mul_start <= 1'b1;
                        r_mul_req   <= '{a: w_rsp.result, b: r_xmag, sh: SH_FRAC,
                                         negb: r_xneg};
                        r_state     <= S_MULX;
                    end
                end
                S_MULX: begin
                    if (w_rsp.done) begin
                        r_t         <= w_rsp.result;
                        r_mul_start <= 1'b1;
                        r_mul_req   <= '{a: r_pm, b: MULB_W'(w_c2), sh: SH_INT,
                                         negb: 1'b0};
                        r_state     <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    if (w_rsp.done) begin
                        r_mul_start <= 1'b1;
                        r_mul_req   <= '{a: sat_sub(r_t, w_rsp.result), b: w_recip[w_d],
                                         sh: SH_RECIP, negb: 1'b0};
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_rsp.done) begin
                        r_pm    <= r_p;
                        r_p     <= w_rsp.result;
                        r_k     <= r_k + DEG_W'(1);
                        r_state <= S_CHECK;
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.value          = r_value;
    assign o_out.previous_value = r_prev;

endmodule
